>>> rtl/lcnc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcnc_pkg
// Shared types, constants and helper functions of the card number classifier.
// ----------------------------------------------------------------------------
package lcnc_pkg;

   localparam int CARD_WIDTH     = 60;
   localparam int BCD_DIGITS     = 19;
   localparam int BCD_WIDTH      = BCD_DIGITS * 4;
   localparam int DEF_MAX_DIGITS = 18;
   localparam int COUNT_WIDTH    = 5;
   localparam int IDX_WIDTH      = $clog2(BCD_DIGITS);
   localparam int STEP_WIDTH     = $clog2(CARD_WIDTH);

   localparam logic [1:0] TYPE_INVALID    = 2'd0;
   localparam logic [1:0] TYPE_AMEX       = 2'd1;
   localparam logic [1:0] TYPE_MASTERCARD = 2'd2;
   localparam logic [1:0] TYPE_VISA       = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic busy;
      logic load;
      logic convert;
      logic scan;
      logic finish;
   } ctrl_type;

   typedef struct packed {
      logic [1:0]             card_type;
      logic                   luhn_ok;
      logic [COUNT_WIDTH-1:0] digit_count;
   } result_type;

   // doubled digit with its two decimal digits added
   function automatic logic [3:0] luhn_double(input logic [3:0] d);
      logic [4:0] p;
      begin
         p = {d, 1'b0};
         if (p > 5'd9) begin
            luhn_double = 4'(p - 5'd9);
         end else begin
            luhn_double = p[3:0];
         end
      end
   endfunction

   function automatic logic [1:0] classify(
      input logic [COUNT_WIDTH-1:0] count,
      input logic [3:0]             hi,
      input logic [3:0]             lo
   );
      begin
         if (count == COUNT_WIDTH'(15) && hi == 4'd3 && (lo == 4'd4 || lo == 4'd7)) begin
            classify = TYPE_AMEX;
         end else if (count == COUNT_WIDTH'(16) && hi == 4'd5 && lo >= 4'd1 && lo <= 4'd5)
         begin
            classify = TYPE_MASTERCARD;
         end else if ((count == COUNT_WIDTH'(13) || count == COUNT_WIDTH'(16)) && hi == 4'd4)
         begin
            classify = TYPE_VISA;
         end else begin
            classify = TYPE_INVALID;
         end
      end
   endfunction

endpackage

>>> rtl/lcnc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcnc_ctrl
// Sequencer: load, one conversion step per input bit, one scan step per
// decimal digit, then hand the result to the output register.
// ----------------------------------------------------------------------------
module lcnc_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              out_free,
   output lcnc_pkg::ctrl_type                ctrl,
   output logic [lcnc_pkg::IDX_WIDTH-1:0]    scan_idx
);
   import lcnc_pkg::*;

   state_type               state_ff, state_in;
   logic [STEP_WIDTH-1:0]   step_ff, step_in;

   localparam logic [STEP_WIDTH-1:0] CONV_LAST = STEP_WIDTH'(CARD_WIDTH - 1);
   localparam logic [STEP_WIDTH-1:0] SCAN_LAST = STEP_WIDTH'(BCD_DIGITS - 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         ST_IDLE: begin
            step_in = '0;
            if (req_valid) begin
               state_in = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            if (step_ff == CONV_LAST) begin
               state_in = ST_SCAN;
               step_in  = '0;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_SCAN: begin
            if (step_ff == SCAN_LAST) begin
               state_in = ST_DONE;
               step_in  = '0;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
            step_in  = '0;
         end
      endcase
   end

   // outputs
   always_comb begin
      ctrl = '0;
      case (state_ff)
         ST_IDLE: begin
            ctrl.load = req_valid;
         end
         ST_CONVERT: begin
            ctrl.busy    = 1'b1;
            ctrl.convert = 1'b1;
         end
         ST_SCAN: begin
            ctrl.busy = 1'b1;
            ctrl.scan = 1'b1;
         end
         ST_DONE: begin
            ctrl.busy   = 1'b1;
            ctrl.finish = out_free;
         end
         default: begin
            ctrl = '0;
         end
      endcase
   end

   assign scan_idx = step_ff[IDX_WIDTH-1:0];

   a_load_starts: assert property (@(posedge clock) disable iff (reset)
      ctrl.load |=> (state_ff == ST_CONVERT && step_ff == '0))
      else $error("load did not start a conversion");

   a_conv_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CONVERT) |-> (step_ff <= CONV_LAST))
      else $error("conversion step out of range");

   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (step_ff <= SCAN_LAST))
      else $error("scan step out of range");

   a_conv_to_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CONVERT && step_ff == CONV_LAST) |=> (state_ff == ST_SCAN))
      else $error("conversion did not hand over to the scan");

endmodule

>>> rtl/lcnc_dabble.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcnc_dabble
// Shift-add-3 binary to decimal converter; afterwards shifts the digits out
// least significant first for the scanner.
// ----------------------------------------------------------------------------
module lcnc_dabble (
   input  logic                               clock,
   input  lcnc_pkg::ctrl_type                 ctrl,
   input  logic [lcnc_pkg::CARD_WIDTH-1:0]    card_number,
   output logic [3:0]                         digit
);
   import lcnc_pkg::*;

   logic [CARD_WIDTH-1:0] bin_ff, bin_in;
   logic [BCD_WIDTH-1:0]  bcd_ff, bcd_in;
   logic [BCD_WIDTH-1:0]  bcd_adj;

   // add 3 to every digit of 5 or more before the shift
   always_comb begin
      for (int g = 0; g < BCD_DIGITS; g++) begin
         if (bcd_ff[g*4 +: 4] >= 4'd5) begin
            bcd_adj[g*4 +: 4] = bcd_ff[g*4 +: 4] + 4'd3;
         end else begin
            bcd_adj[g*4 +: 4] = bcd_ff[g*4 +: 4];
         end
      end
   end

   always_comb begin
      bin_in = bin_ff;
      bcd_in = bcd_ff;
      if (ctrl.load) begin
         bin_in = card_number;
         bcd_in = '0;
      end else if (ctrl.convert) begin
         bin_in = {bin_ff[CARD_WIDTH-2:0], 1'b0};
         bcd_in = {bcd_adj[BCD_WIDTH-2:0], bin_ff[CARD_WIDTH-1]};
      end else if (ctrl.scan) begin
         bcd_in = {4'd0, bcd_ff[BCD_WIDTH-1:4]};
      end
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign digit = bcd_ff[3:0];

endmodule

>>> rtl/lcnc_luhn.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcnc_luhn
// Digit scanner: running Luhn sum modulo ten, digit count and the two
// leading digits, then the card type.
// ----------------------------------------------------------------------------
module lcnc_luhn #(
   parameter int MAX_DIGITS = lcnc_pkg::DEF_MAX_DIGITS
) (
   input  logic                              clock,
   input  lcnc_pkg::ctrl_type                ctrl,
   input  logic [3:0]                        digit,
   input  logic [lcnc_pkg::IDX_WIDTH-1:0]    scan_idx,
   output lcnc_pkg::result_type              result
);
   import lcnc_pkg::*;

   logic [3:0]             sum_ff, sum_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [3:0]             hi_ff, hi_in;
   logic [3:0]             lo_ff, lo_in;
   logic [3:0]             prev_ff, prev_in;
   logic [3:0]             addend;
   logic [4:0]             sum_raw;

   assign addend  = scan_idx[0] ? luhn_double(digit) : digit;
   assign sum_raw = {1'b0, sum_ff} + {1'b0, addend};

   always_comb begin
      sum_in   = sum_ff;
      count_in = count_ff;
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      prev_in  = prev_ff;
      if (ctrl.load) begin
         sum_in   = '0;
         count_in = '0;
         hi_in    = '0;
         lo_in    = '0;
         prev_in  = '0;
      end else if (ctrl.scan) begin
         sum_in  = (sum_raw >= 5'd10) ? 4'(sum_raw - 5'd10) : sum_raw[3:0];
         prev_in = digit;
         // highest nonzero digit so far is the leading one
         if (digit != 4'd0) begin
            count_in = COUNT_WIDTH'(scan_idx) + 1'b1;
            hi_in    = digit;
            lo_in    = (scan_idx == '0) ? digit : prev_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      sum_ff   <= sum_in;
      count_ff <= count_in;
      hi_ff    <= hi_in;
      lo_ff    <= lo_in;
      prev_ff  <= prev_in;
   end

   always_comb begin
      if (count_ff > COUNT_WIDTH'(MAX_DIGITS)) begin
         result.card_type   = TYPE_INVALID;
         result.luhn_ok     = 1'b0;
         result.digit_count = COUNT_WIDTH'(MAX_DIGITS + 1);
      end else begin
         result.luhn_ok     = (sum_ff == 4'd0);
         result.digit_count = count_ff;
         if (sum_ff == 4'd0 && count_ff != '0) begin
            result.card_type = classify(count_ff, hi_ff, lo_ff);
         end else begin
            result.card_type = TYPE_INVALID;
         end
      end
   end

endmodule

>>> rtl/luhn_card_number_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// luhn_card_number_classifier
// Converts a binary card number to decimal, runs the Luhn mod-10 check and
// classifies the card as amex, mastercard or visa.
//
// Usage:
//   request channel: req_valid / req_stall with req_card_number (60 bits).
//   A word is taken when req_valid is high and req_stall is low.
//   response channel: rsp_valid / rsp_stall with rsp_card_type, rsp_luhn_ok
//   and rsp_digit_count; a word leaves when rsp_valid is high and rsp_stall
//   is low.
//   The number is loaded at the accepting edge, then converted by shift-add-3
//   (one step per input bit), its decimal digits are scanned (one step per
//   digit) and the result is handed to the output register. One number is
//   worked on at a time; req_stall stays high from the cycle after
//   acceptance until the result moves into the output register, and the
//   next request can be taken in the cycle after that.
//   While the receiver stalls, the response word holds; the block may take
//   the next request but keeps its finished result until the output
//   register frees up.
//   Reset (synchronous, active high) returns the sequencer to idle and
//   drops rsp_valid; no clearing pass is needed.
// ----------------------------------------------------------------------------
module luhn_card_number_classifier #(
   parameter int MAX_DIGITS = lcnc_pkg::DEF_MAX_DIGITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [lcnc_pkg::CARD_WIDTH-1:0]     req_card_number,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [1:0]                          rsp_card_type,
   output logic                                rsp_luhn_ok,
   output logic [lcnc_pkg::COUNT_WIDTH-1:0]    rsp_digit_count
);
   import lcnc_pkg::*;

   ctrl_type               ctrl;
   logic [IDX_WIDTH-1:0]   scan_idx;
   logic [3:0]             digit;
   result_type             result;
   logic                   out_free;
   logic                   rsp_valid_ff, rsp_valid_in;
   result_type             rsp_word_ff, rsp_word_in;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   lcnc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .out_free  (out_free),
      .ctrl      (ctrl),
      .scan_idx  (scan_idx)
   );

   lcnc_dabble u_dabble (
      .clock       (clock),
      .ctrl        (ctrl),
      .card_number (req_card_number),
      .digit       (digit)
   );

   lcnc_luhn #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_luhn (
      .clock    (clock),
      .ctrl     (ctrl),
      .digit    (digit),
      .scan_idx (scan_idx),
      .result   (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (ctrl.finish) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = result;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_word_ff <= rsp_word_in;
   end

   assign req_stall       = ctrl.busy;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_card_type   = rsp_word_ff.card_type;
   assign rsp_luhn_ok     = rsp_word_ff.luhn_ok;
   assign rsp_digit_count = rsp_word_ff.digit_count;

   a_type_needs_luhn: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_word_ff.card_type != TYPE_INVALID) |-> rsp_word_ff.luhn_ok)
      else $error("card type given without a passing check");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_word_ff.digit_count <= COUNT_WIDTH'(MAX_DIGITS + 1)))
      else $error("digit count out of range");

endmodule
